FILE: rtl/spg_pkg.sv
// Package for the special pair generator: default sizes and the fixed
// widths of the stream payloads. No dependencies.
`default_nettype none

package spg_pkg;

  // Defaults for the top-level parameters
  localparam int STACK_DEPTH_DEF    = 64;
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF    = 32;

  // Fixed field widths on the stream ports
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_POS_W   = 16;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_DATA_W  = 2 * OUT_POS_W + 2 * OUT_VALUE_W;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

FILE: rtl/spg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spg_fifo.sv
// Short register queue between the front and back of the pair generator.
// Depends on spg_pkg for its depth.
`default_nettype none

module spg_fifo #(
  parameter int WIDTH = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int DEPTH = spg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spg_front.sv
// Front of the pair generator: takes input words, brings the sample to the
// internal value width and hands value plus restart flag to the queue.
// Depends on spg_pkg.
`default_nettype none

module spg_front #(
  parameter int VALUE_WIDTH = spg_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [spg_pkg::IN_VALUE_W-1:0] in_value,
  input  wire logic                           in_new_seq,
  output logic                                item_valid,
  input  wire logic                           item_ready,
  output logic      [VALUE_WIDTH:0]           item_data
);

  logic                          held;
  logic signed [VALUE_WIDTH-1:0] held_value;
  logic                          held_new_seq;
  logic signed [VALUE_WIDTH-1:0] conv_value;

  // Sign-extend or wrap the 32-bit sample to the internal width
  assign conv_value = VALUE_WIDTH'(signed'(in_value));

  assign in_ready   = !held || item_ready;
  assign item_valid = held;
  assign item_data  = {held_new_seq, held_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_value   <= conv_value;
      held_new_seq <= in_new_seq;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spg_back.sv
// Back of the pair generator: pops the candidate stack, walks it to emit
// pairs, pushes the new value. Stack lives in spg_ram; depends on spg_pkg.
`default_nettype none

module spg_back #(
  parameter int STACK_DEPTH    = spg_pkg::STACK_DEPTH_DEF,
  parameter int POSITION_WIDTH = spg_pkg::POSITION_WIDTH_DEF,
  parameter int VALUE_WIDTH    = spg_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire logic [VALUE_WIDTH:0]           item_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [spg_pkg::OUT_DATA_W-1:0] out_data,
  output logic                                out_last,
  output logic                                out_ovf
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W = POSITION_WIDTH + 2 * VALUE_WIDTH;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                    state, state_next;
  logic signed [VALUE_WIDTH-1:0] x, x_next;
  logic [POSITION_WIDTH-1:0]     pos_cur, pos_cur_next;
  logic [POSITION_WIDTH-1:0]     position, position_next;
  logic [FILL_W-1:0]             fill, fill_next;
  logic [FILL_W-1:0]             j, j_next;
  logic                          overflow, overflow_next;
  logic                          pend_valid, pend_valid_next;
  logic [POSITION_WIDTH-1:0]     pend_pos, pend_pos_next;
  logic signed [VALUE_WIDTH-1:0] pend_val, pend_val_next;

  logic                          load_out;
  logic                          load_last;
  logic                          out_free;
  logic                          in_new_seq;
  logic [FILL_W-1:0]             fill_eff;
  logic [POSITION_WIDTH-1:0]     pos_eff;

  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [WORD_W-1:0]             wr_data;
  logic                          rd_en;
  logic [ADDR_W-1:0]             rd_addr;
  logic [WORD_W-1:0]             rd_data;
  logic [POSITION_WIDTH-1:0]     rd_pos;
  logic signed [VALUE_WIDTH-1:0] rd_val;
  logic signed [VALUE_WIDTH-1:0] rd_best;

  // Stack word: best end on top, then value, then position
  spg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_pos  = rd_data[POSITION_WIDTH-1:0];
  assign rd_val  = rd_data[POSITION_WIDTH +: VALUE_WIDTH];
  assign rd_best = rd_data[POSITION_WIDTH + VALUE_WIDTH +: VALUE_WIDTH];

  assign out_free   = !out_valid || out_ready;
  assign in_new_seq = item_data[VALUE_WIDTH];
  assign fill_eff   = in_new_seq ? '0 : fill;
  assign pos_eff    = in_new_seq ? '0 : position;

  always_comb begin
    state_next      = state;
    x_next          = x;
    pos_cur_next    = pos_cur;
    position_next   = position;
    fill_next       = fill;
    j_next          = j;
    overflow_next   = overflow;
    pend_valid_next = pend_valid;
    pend_pos_next   = pend_pos;
    pend_val_next   = pend_val;
    load_out        = 1'b0;
    load_last       = 1'b0;
    item_ready      = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          x_next        = item_data[VALUE_WIDTH-1:0];
          pos_cur_next  = pos_eff;
          position_next = pos_eff + POSITION_WIDTH'(1);
          fill_next     = fill_eff;
          if (fill_eff == '0) begin
            state_next = S_FLUSH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = ADDR_W'(fill_eff - FILL_W'(1));
            state_next = S_POP;
          end
        end
      end

      S_POP: begin
        // Data in hand is the top entry, index fill-1
        if (x <= rd_val) begin
          fill_next = fill - FILL_W'(1);
          if (fill == FILL_W'(1)) begin
            state_next = S_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(fill - FILL_W'(2));
          end
        end else begin
          j_next        = fill;
          overflow_next = overflow || (fill == FILL_W'(STACK_DEPTH));
          state_next    = S_WALK;
        end
      end

      S_WALK: begin
        // Data in hand is entry j-1
        if (rd_best < x) begin
          if (!pend_valid || out_free) begin
            load_out        = pend_valid;
            pend_valid_next = 1'b1;
            pend_pos_next   = rd_pos;
            pend_val_next   = rd_val;
            wr_en           = 1'b1;
            wr_addr         = ADDR_W'(j - FILL_W'(1));
            wr_data         = {x, rd_val, rd_pos};
            j_next          = j - FILL_W'(1);
            if (j == FILL_W'(1)) begin
              state_next = S_FLUSH;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ADDR_W'(j - FILL_W'(2));
            end
          end
        end else begin
          state_next = S_FLUSH;
        end
      end

      S_FLUSH: begin
        // Release the held pair as last of run, then push
        if (!pend_valid || out_free) begin
          load_out        = pend_valid;
          load_last       = 1'b1;
          pend_valid_next = 1'b0;
          if (fill < FILL_W'(STACK_DEPTH)) begin
            wr_en     = 1'b1;
            wr_addr   = ADDR_W'(fill);
            wr_data   = {x, x, pos_cur};
            fill_next = fill + FILL_W'(1);
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      position   <= '0;
      fill       <= '0;
      j          <= '0;
      overflow   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      position   <= position_next;
      fill       <= fill_next;
      j          <= j_next;
      overflow   <= overflow_next;
      pend_valid <= pend_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x        <= x_next;
    pos_cur  <= pos_cur_next;
    pend_pos <= pend_pos_next;
    pend_val <= pend_val_next;
    if (load_out) begin
      out_data <= {spg_pkg::OUT_VALUE_W'(x),
                   spg_pkg::OUT_VALUE_W'(pend_val),
                   spg_pkg::OUT_POS_W'(pos_cur),
                   spg_pkg::OUT_POS_W'(pend_pos)};
      out_last <= load_last;
      out_ovf  <= overflow;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(STACK_DEPTH))
    else $error("stack fill above depth");

  a_walk_index: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (j != '0) && (j <= fill))
    else $error("walk index outside stack");

  a_pend_state: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_WALK) || (state == S_FLUSH))
    else $error("held pair outside walk");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag dropped");

  a_no_lost_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

FILE: rtl/special_pair_generator_unit.sv
// Top level of the special pair generator: front, queue and back joined
// to the stream ports. Depends on spg_pkg, spg_front, spg_fifo, spg_back.
`default_nettype none

// Reads a stream of signed samples, numbered from zero (tuser restarts the
// numbering and empties the candidate stack), and emits one output word per
// pair of start candidate and current sample; tlast marks the last pair of
// a sample, and a sample that makes no pair gives no word. Input words are
// taken into a two-entry queue while the back end works, so the input side
// keeps flowing for a few samples. For each sample the back end takes the
// sample in, pops each entry whose value is not below it, emits one pair
// per entry it walks, looks at the entry that stops each scan and pushes
// the sample, in separate steps because the candidate stack sits in a RAM
// with one registered read per cycle. Output stalls hold the back end only
// when a second pair waits behind an untaken one. When the stack is full
// the new sample is not pushed and the sticky overflow bit in tuser is set
// until reset.
module special_pair_generator_unit #(
  parameter int STACK_DEPTH    = spg_pkg::STACK_DEPTH_DEF,
  parameter int POSITION_WIDTH = spg_pkg::POSITION_WIDTH_DEF,
  parameter int VALUE_WIDTH    = spg_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [spg_pkg::IN_VALUE_W-1:0] s_axis_tdata,  // sample_value
  input  wire logic                           s_axis_tuser,  // new_sequence
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // pair_start, pair_end, start_value, end_value
  output logic      [spg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                m_axis_tlast,  // last_of_run
  output logic                                m_axis_tuser   // overflow_seen
);

  logic                 front_valid;
  logic                 front_ready;
  logic [VALUE_WIDTH:0] front_data;
  logic                 item_valid;
  logic                 item_ready;
  logic [VALUE_WIDTH:0] item_data;

  spg_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata),
    .in_new_seq (s_axis_tuser),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item_data  (front_data)
  );

  spg_fifo #(
    .WIDTH (VALUE_WIDTH + 1)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (item_valid),
    .pop_ready  (item_ready),
    .pop_data   (item_data)
  );

  spg_back #(
    .STACK_DEPTH    (STACK_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH),
    .VALUE_WIDTH    (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_ovf    (m_axis_tuser)
  );

endmodule

`default_nettype wire
